// ===== src/dram_row_buffer_latency_top_assert.svh =====
// assertion macros for the dram row buffer latency block
// expects clk_i and rst_ni in the scope of each use
`ifndef DRAM_ROW_BUFFER_LATENCY_TOP_ASSERT_SVH
`define DRAM_ROW_BUFFER_LATENCY_TOP_ASSERT_SVH

// same-cycle implication
`define DRL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DRL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/drl_pkg.sv =====
// shared types, constants and helpers for the dram row buffer latency block
// no dependencies
`default_nettype none

package drl_pkg;

  localparam int unsigned BankCountDef = 16;
  localparam int unsigned AddrW        = 32;
  localparam int unsigned LatW         = 12;
  localparam int unsigned TermW        = 10;
  localparam int unsigned CntW         = 32;
  localparam int unsigned SumW         = 48;
  localparam int unsigned ShiftW       = 5;
  localparam int unsigned ApbAddrW     = 5;
  localparam int unsigned ApbDataW     = 32;
  localparam int unsigned RegIdxW      = 3;
  localparam int unsigned OutDataW     = 272;

  typedef enum logic [1:0] {
    OUT_NONE  = 2'd0,
    OUT_EMPTY = 2'd1,
    OUT_HIT   = 2'd2,
    OUT_MISS  = 2'd3
  } outcome_e;

  typedef enum logic [RegIdxW-1:0] {
    REG_PAGE_POLICY        = 3'd0,
    REG_LINES_PER_ROW_LOG2 = 3'd1,
    REG_ACTIVATE_LATENCY   = 3'd2,
    REG_COL_CYCLES         = 3'd3,
    REG_PRECHARGE_LATENCY  = 3'd4,
    REG_XFER_CYCLES        = 3'd5
  } reg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CALC
  } state_e;

  typedef struct packed {
    logic             page_policy;
    logic [3:0]       lines_per_row_log2;
    logic [TermW-1:0] activate_latency;
    logic [TermW-1:0] col_cycles;
    logic [TermW-1:0] precharge_latency;
    logic [TermW-1:0] xfer_cycles;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    page_policy:        1'b0,
    lines_per_row_log2: 4'd6,
    activate_latency:   10'd45,
    col_cycles:         10'd45,
    precharge_latency:  10'd45,
    xfer_cycles:        10'd10
  };

  typedef struct packed {
    logic capture;
    logic lookup;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

  // trailing zero bits of the bank count
  function automatic int unsigned bank_bits(input int unsigned count);
    int unsigned n;
    int unsigned b;
    n = count;
    b = 0;
    for (int i = 0; i < 31; i++) begin
      if ((n != 0) && ((n & 1) == 0)) begin
        n = n >> 1;
        b = b + 1;
      end
    end
    return b;
  endfunction

endpackage

`default_nettype wire

// ===== src/drl_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module drl_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== src/drl_ctrl.sv =====
// sequencing state machine: accept, row lookup, compute and commit
// depends on drl_pkg
`default_nettype none

module drl_ctrl import drl_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_valid_i,
  input  dp_status_t status_i,
  output logic       s_ready_o,
  output ctrl_cmd_t  cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    s_ready_o = 1'b0;
    cmd_o     = '0;
    case (state_q)
      ST_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.lookup = 1'b1;
        state_d      = ST_CALC;
      end
      ST_CALC: begin
        if (status_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== src/drl_dp.sv =====
// datapath: bank and row split, open row ram, latency select, statistics
// depends on drl_pkg, drl_ram and the assertion macro header
`default_nettype none

`include "dram_row_buffer_latency_top_assert.svh"

module drl_dp import drl_pkg::*; #(
  parameter int unsigned BANK_COUNT = BankCountDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cfg_t                cfg_i,
  input  ctrl_cmd_t           cmd_i,
  output dp_status_t          status_o,
  input  logic [AddrW-1:0]    in_addr_i,
  input  logic                in_wr_i,
  output logic                m_valid_o,
  input  logic                m_ready_i,
  output logic [OutDataW-1:0] m_data_o
);

  localparam int unsigned BankBits  = bank_bits(BANK_COUNT);
  localparam int unsigned BankAw    = (BankBits > 0) ? BankBits : 1;
  localparam int unsigned BankDepth = 1 << BankBits;

  logic [AddrW-1:0]     addr_q;
  logic                 wr_q;
  logic [AddrW-1:0]     shifted;
  logic [ShiftW-1:0]    row_sh;
  logic [AddrW-1:0]     row;
  logic [BankAw-1:0]    bank;
  logic [AddrW-1:0]     ram_row;
  logic [BankDepth-1:0] valid_q;
  logic                 ram_we;

  logic [LatW-1:0] lat_short, lat_act, lat_full, lat_d, lat_q;
  outcome_e        outcome_d, outcome_q;

  logic            m_valid_q;
  logic [CntW-1:0] reads_q, writes_q, hits_q, misses_q, empties_q;
  logic [SumW-1:0] rsum_q, wsum_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      addr_q <= in_addr_i;
      wr_q   <= in_wr_i;
    end
  end

  always_comb begin
    shifted = addr_q >> cfg_i.lines_per_row_log2;
    row_sh  = ShiftW'(cfg_i.lines_per_row_log2) + ShiftW'(BankBits);
    row     = addr_q >> row_sh;
    if (BankBits == 0) begin
      bank = '0;
    end else begin
      bank = shifted[BankAw-1:0];
    end
  end

  assign ram_we = cmd_i.commit && !cfg_i.page_policy;

  drl_ram #(
    .WIDTH (AddrW),
    .DEPTH (BankDepth)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (bank),
    .wdata_i (row),
    .re_i    (cmd_i.lookup),
    .raddr_i (bank),
    .rdata_o (ram_row)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (ram_we) begin
      valid_q[bank] <= 1'b1;
    end
  end

  assign lat_short = LatW'(cfg_i.col_cycles) + LatW'(cfg_i.xfer_cycles);
  assign lat_act   = lat_short + LatW'(cfg_i.activate_latency);
  assign lat_full  = lat_act + LatW'(cfg_i.precharge_latency);

  always_comb begin
    lat_d     = lat_act;
    outcome_d = OUT_NONE;
    if (!cfg_i.page_policy) begin
      if (wr_q) begin
        lat_d = lat_full;
      end else if (!valid_q[bank]) begin
        lat_d     = lat_act;
        outcome_d = OUT_EMPTY;
      end else if (ram_row == row) begin
        lat_d     = lat_short;
        outcome_d = OUT_HIT;
      end else begin
        lat_d     = lat_full;
        outcome_d = OUT_MISS;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      lat_q     <= lat_d;
      outcome_q <= outcome_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reads_q   <= '0;
      writes_q  <= '0;
      rsum_q    <= '0;
      wsum_q    <= '0;
      hits_q    <= '0;
      misses_q  <= '0;
      empties_q <= '0;
    end else if (cmd_i.commit) begin
      if (wr_q) begin
        writes_q <= writes_q + CntW'(1);
        wsum_q   <= wsum_q + SumW'(lat_d);
      end else begin
        reads_q <= reads_q + CntW'(1);
        rsum_q  <= rsum_q + SumW'(lat_d);
      end
      case (outcome_d)
        OUT_EMPTY: empties_q <= empties_q + CntW'(1);
        OUT_HIT:   hits_q    <= hits_q + CntW'(1);
        OUT_MISS:  misses_q  <= misses_q + CntW'(1);
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      m_valid_q <= 1'b1;
    end else if (m_ready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  assign status_o.out_free = !m_valid_q || m_ready_i;
  assign m_valid_o         = m_valid_q;
  assign m_data_o          = {2'b00, empties_q, misses_q, hits_q, wsum_q, rsum_q,
                              writes_q, reads_q, outcome_q, lat_q};

  `DRL_ASSERT_NXT(a_commit_shows, cmd_i.commit, m_valid_q, "commit without result")
  `DRL_ASSERT_NXT(a_read_counted, cmd_i.commit && !wr_q,
                  reads_q == $past(reads_q) + CntW'(1), "read count not advanced")
  `DRL_ASSERT_NXT(a_stats_hold, !cmd_i.commit,
                  $stable(reads_q) && $stable(writes_q) && $stable(hits_q),
                  "statistics changed without commit")
  `DRL_ASSERT_NXT(a_close_keeps_rows, cmd_i.commit && cfg_i.page_policy,
                  $stable(valid_q), "close page touched row buffers")

endmodule

`default_nettype wire

// ===== src/dram_row_buffer_latency_top.sv =====
// after the read and calc states, commit registers the item's result as valid
// a new item is accepted only in idle, once the previous item is committed
// a stalled result blocks the commit of the next item but not its acceptance
// reset: registers to their default values, statistics to zero, all row buffers empty
// top level of the dram row buffer latency block, with the register port
// depends on drl_pkg, drl_ctrl and drl_dp
`default_nettype none

module dram_row_buffer_latency_top import drl_pkg::*; #(
  parameter int unsigned BANK_COUNT = BankCountDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [AddrW-1:0]    s_axis_tdata,   // line_address
  input  logic                s_axis_tuser,   // is_write
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // latency, outcome, read_count, write_count, read_delay_sum, write_delay_sum,
  // hit_count, miss_count, empty_count, zero pad
  output logic [OutDataW-1:0] m_axis_tdata,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  cfg_t               cfg_q;
  logic [RegIdxW-1:0] reg_idx;
  logic               cfg_we;
  ctrl_cmd_t          cmd;
  dp_status_t         status;

  assign reg_idx = paddr[ApbAddrW-1:2];
  assign cfg_we  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else if (cfg_we) begin
      case (reg_idx)
        REG_PAGE_POLICY:        cfg_q.page_policy        <= pwdata[0];
        REG_LINES_PER_ROW_LOG2: cfg_q.lines_per_row_log2 <= pwdata[3:0];
        REG_ACTIVATE_LATENCY:   cfg_q.activate_latency   <= pwdata[TermW-1:0];
        REG_COL_CYCLES:         cfg_q.col_cycles         <= pwdata[TermW-1:0];
        REG_PRECHARGE_LATENCY:  cfg_q.precharge_latency  <= pwdata[TermW-1:0];
        REG_XFER_CYCLES:        cfg_q.xfer_cycles        <= pwdata[TermW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_PAGE_POLICY:        prdata = ApbDataW'(cfg_q.page_policy);
      REG_LINES_PER_ROW_LOG2: prdata = ApbDataW'(cfg_q.lines_per_row_log2);
      REG_ACTIVATE_LATENCY:   prdata = ApbDataW'(cfg_q.activate_latency);
      REG_COL_CYCLES:         prdata = ApbDataW'(cfg_q.col_cycles);
      REG_PRECHARGE_LATENCY:  prdata = ApbDataW'(cfg_q.precharge_latency);
      REG_XFER_CYCLES:        prdata = ApbDataW'(cfg_q.xfer_cycles);
      default:                prdata = '0;
    endcase
  end

  drl_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .status_i  (status),
    .s_ready_o (s_axis_tready),
    .cmd_o     (cmd)
  );

  drl_dp #(
    .BANK_COUNT (BANK_COUNT)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .cmd_i     (cmd),
    .status_o  (status),
    .in_addr_i (s_axis_tdata),
    .in_wr_i   (s_axis_tuser),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_data_o  (m_axis_tdata)
  );

endmodule

`default_nettype wire
